// ===== hdl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg: shared types and constants of the battery level estimator
// microcode word layout, the step program, the charge curve and the register map
// ----------------------------------------------------------------------------
`default_nettype none

package ble_pkg;

  // window length in converter attempts
  localparam int unsigned SAMPLE_COUNT = 16;

  // field widths
  localparam int unsigned CODE_W = 12;
  localparam int unsigned MV_W   = 12;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned GOOD_W = 5;
  localparam int unsigned BAT_W  = 16;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned RAT_W  = 12;
  localparam int unsigned THR_W  = 15;
  localparam int unsigned PROD_W = 28;

  // shared divider: dividend and divisor widths
  localparam int unsigned DIV_W  = 20;
  localparam int unsigned DEN_W  = 9;
  localparam int unsigned DCNT_W = 5;

  // configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_DIVIDER_RATIO = 2'd0,
    REG_FULL_SCALE    = 2'd1,
    REG_PRESENT_MIN   = 2'd2,
    REG_VALID_MAX     = 2'd3
  } ble_reg_t;

  localparam logic [RAT_W-1:0] RESET_RATIO      = 12'd768;
  localparam logic [MV_W-1:0]  RESET_FULL_SCALE = 12'd3300;
  localparam logic [THR_W-1:0] RESET_PRESENT    = 15'd3150;
  localparam logic [THR_W-1:0] RESET_VALID_MAX  = 15'd4350;

  localparam logic [MV_W:0]    CODE_FULL = 13'd4095;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // datapath operation of a step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCALE,
    OP_SAMPLE,
    OP_WINDOW,
    OP_DIV_AVG,
    OP_SAT,
    OP_DIV_SOC,
    OP_PCT,
    OP_EMIT,
    OP_EMIT_EMPTY
  } ble_op_t;

  // sequencing condition of a step
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_IN,
    COND_MORE,
    COND_EMPTY,
    COND_CLAMP,
    COND_DIV,
    COND_OUT
  } ble_cond_t;

  typedef logic [3:0] ble_pc_t;

  typedef struct packed {
    logic      take;
    ble_op_t   op;
    ble_cond_t cond;
    ble_pc_t   target;
  } ble_uword_t;

  // step addresses
  localparam ble_pc_t STEP_ACCEPT  = 4'd0;
  localparam ble_pc_t STEP_SCALE   = 4'd1;
  localparam ble_pc_t STEP_SAMPLE  = 4'd2;
  localparam ble_pc_t STEP_WINDOW  = 4'd3;
  localparam ble_pc_t STEP_AVG_DIV = 4'd4;
  localparam ble_pc_t STEP_AVG_WT  = 4'd5;
  localparam ble_pc_t STEP_SOC     = 4'd6;
  localparam ble_pc_t STEP_SOC_WT  = 4'd7;
  localparam ble_pc_t STEP_EMIT    = 4'd8;
  localparam ble_pc_t STEP_EMPTY   = 4'd9;

  // microcode program
  function automatic ble_uword_t ucode_rom(input ble_pc_t pc);
    ble_uword_t w;
    w = '{take: 1'b0, op: OP_NONE, cond: COND_NEXT, target: STEP_ACCEPT};
    unique case (pc)
      STEP_ACCEPT:  w = '{1'b1, OP_LATCH,      COND_IN,    STEP_ACCEPT};
      STEP_SCALE:   w = '{1'b0, OP_SCALE,      COND_NEXT,  STEP_ACCEPT};
      STEP_SAMPLE:  w = '{1'b0, OP_SAMPLE,     COND_MORE,  STEP_ACCEPT};
      STEP_WINDOW:  w = '{1'b0, OP_WINDOW,     COND_EMPTY, STEP_EMPTY};
      STEP_AVG_DIV: w = '{1'b0, OP_DIV_AVG,    COND_NEXT,  STEP_ACCEPT};
      STEP_AVG_WT:  w = '{1'b0, OP_SAT,        COND_DIV,   STEP_ACCEPT};
      STEP_SOC:     w = '{1'b0, OP_DIV_SOC,    COND_CLAMP, STEP_EMIT};
      STEP_SOC_WT:  w = '{1'b0, OP_PCT,        COND_DIV,   STEP_ACCEPT};
      STEP_EMIT:    w = '{1'b0, OP_EMIT,       COND_OUT,   STEP_ACCEPT};
      STEP_EMPTY:   w = '{1'b0, OP_EMIT_EMPTY, COND_OUT,   STEP_ACCEPT};
      default:      w = '{1'b0, OP_NONE,       COND_OUT,   STEP_ACCEPT};
    endcase
    return w;
  endfunction

  // charge curve breakpoints, full to empty
  function automatic logic [12:0] curve_mv(input logic [3:0] idx);
    logic [12:0] v;
    v = 13'd3300;
    unique case (idx)
      4'd0:    v = 13'd4200;
      4'd1:    v = 13'd4100;
      4'd2:    v = 13'd4000;
      4'd3:    v = 13'd3920;
      4'd4:    v = 13'd3850;
      4'd5:    v = 13'd3790;
      4'd6:    v = 13'd3730;
      4'd7:    v = 13'd3680;
      4'd8:    v = 13'd3600;
      4'd9:    v = 13'd3500;
      default: v = 13'd3300;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [3:0] idx);
    logic [PCT_W-1:0] p;
    p = 7'd0;
    unique case (idx)
      4'd0:    p = 7'd100;
      4'd1:    p = 7'd90;
      4'd2:    p = 7'd80;
      4'd3:    p = 7'd70;
      4'd4:    p = 7'd60;
      4'd5:    p = 7'd50;
      4'd6:    p = 7'd40;
      4'd7:    p = 7'd30;
      4'd8:    p = 7'd20;
      4'd9:    p = 7'd10;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ble_in_if.sv =====
// ----------------------------------------------------------------------------
// ble_in_if: sample attempt channel
// one beat per converter attempt, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface ble_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] raw_code;
  logic        read_ok;
  logic        cal_ok;
  logic [11:0] cal_mv;
  logic        usb_present;

  modport source (
    output valid, raw_code, read_ok, cal_ok, cal_mv, usb_present,
    input  ready
  );

  modport sink (
    input  valid, raw_code, read_ok, cal_ok, cal_mv, usb_present,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/ble_out_if.sv =====
// ----------------------------------------------------------------------------
// ble_out_if: battery level result channel
// one beat per window, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface ble_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] battery_mv;
  logic [6:0]  percent;
  logic        external_power;
  logic        no_samples;

  modport source (
    output valid, battery_mv, percent, external_power, no_samples,
    input  ready
  );

  modport sink (
    input  valid, battery_mv, percent, external_power, no_samples,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/battery_level_estimator_core.sv =====
// ----------------------------------------------------------------------------
// battery_level_estimator_core: windowed battery voltage and charge estimate
// microcoded sequencer over a small datapath with one shared serial divider
//
//   channel   dir  beat
//   in_ch     in   one converter attempt (raw code, status, calibrated mv, usb)
//   out_ch    out  one result per window of SAMPLE_COUNT attempts
//   apb       in   register writes and reads, pready tied high
//
// an attempt runs the steps accept, scale multiply, accumulate
// the last attempt of a window adds the average and curve divisions, each a
// restoring divider pass; off the curve one, for an empty window none
// the result sits in an output register, so the next attempt is accepted
// while it waits; the emit step stalls only when a second result is ready
// synchronous active-low reset returns registers to defaults, empty window
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_estimator_core
  import ble_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  ble_in_if.sink            in_ch,
  ble_out_if.source         out_ch,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [ADDR_W-1:0] paddr,
  input  wire  [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [RAT_W-1:0] ratio_r, ratio_nxt;
  logic [MV_W-1:0]  fs_r, fs_nxt;
  logic [THR_W-1:0] pmin_r, pmin_nxt;
  logic [THR_W-1:0] vmax_r, vmax_nxt;

  // sequencer
  ble_pc_t    pc_r, pc_nxt;
  ble_uword_t uw;
  logic       go;

  // latched attempt
  logic [CODE_W-1:0] raw_r, raw_nxt;
  logic              read_ok_r, read_ok_nxt;
  logic              cal_ok_r, cal_ok_nxt;
  logic [MV_W-1:0]   cal_mv_r, cal_mv_nxt;
  logic              usb_r, usb_nxt;

  // window state and working registers
  logic [CNT_W-1:0]  attempt_r, attempt_nxt;
  logic [GOOD_W-1:0] good_r, good_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [BAT_W-1:0]  bat_r, bat_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;

  // shared divider
  logic              div_busy_r, div_busy_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [DIV_W-1:0]  div_quo_r, div_quo_nxt;
  logic [DEN_W-1:0]  div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0]  div_den_r, div_den_nxt;
  logic [DEN_W:0]    div_trial;
  logic              div_fits;

  // output register
  logic              ov_r, ov_nxt;
  logic [BAT_W-1:0]  o_bat_r, o_bat_nxt;
  logic [PCT_W-1:0]  o_pct_r, o_pct_nxt;
  logic              o_ext_r, o_ext_nxt;
  logic              o_none_r, o_none_nxt;

  // datapath helpers
  logic              in_beat, out_free, more, clamp, clamp_hi;
  logic [MV_W-1:0]   lin_q0, mv_lin, sample_mv;
  logic [MV_W:0]     lin_rem;
  logic [3:0]        seg;
  logic [12:0]       seg_hi, seg_lo, soc_num;
  logic [7:0]        seg_span, seg_diff;
  logic              cfg_wr;

  assign uw       = ucode_rom(pc_r);
  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign more     = ({1'b0, attempt_r} + 5'd1) < 5'(SAMPLE_COUNT);

  // ports
  assign in_ch.ready           = uw.take;
  assign out_ch.valid          = ov_r;
  assign out_ch.battery_mv     = o_bat_r;
  assign out_ch.percent        = o_pct_r;
  assign out_ch.external_power = o_ext_r;
  assign out_ch.no_samples     = o_none_r;
  assign pready                = 1'b1;
  assign cfg_wr                = psel && penable && pwrite;

  // register readback
  always_comb begin
    case (ble_reg_t'(paddr[3:2]))
      REG_DIVIDER_RATIO: prdata = {20'd0, ratio_r};
      REG_FULL_SCALE:    prdata = {20'd0, fs_r};
      REG_PRESENT_MIN:   prdata = {17'd0, pmin_r};
      REG_VALID_MAX:     prdata = {17'd0, vmax_r};
      default:           prdata = '0;
    endcase
  end

  // divide by 4095: x>>12 undershoots by at most one
  assign lin_q0    = prod_r[23:12];
  assign lin_rem   = {1'b0, prod_r[11:0]} + {1'b0, lin_q0};
  assign mv_lin    = lin_q0 + MV_W'(lin_rem >= CODE_FULL);
  assign sample_mv = cal_ok_r ? cal_mv_r : mv_lin;

  // curve segment of the averaged voltage
  assign clamp_hi = bat_r >= {3'd0, curve_mv(4'd0)};
  assign clamp    = clamp_hi || (bat_r <= {3'd0, curve_mv(4'd10)});

  always_comb begin
    seg = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (bat_r < {3'd0, curve_mv(4'(k))}) begin
        seg = seg + 4'd1;
      end
    end
  end

  assign seg_hi   = curve_mv(seg);
  assign seg_lo   = curve_mv(seg + 4'd1);
  assign seg_span = 8'(seg_hi - seg_lo);
  assign seg_diff = 8'(bat_r - {3'd0, seg_lo});
  assign soc_num  = 13'({5'd0, seg_diff} * 13'd20) + {5'd0, seg_span};

  // divider step
  assign div_trial = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_fits  = div_trial >= {1'b0, div_den_r};

  // sequencing
  always_comb begin
    go     = 1'b1;
    pc_nxt = pc_r + 4'd1;
    unique case (uw.cond)
      COND_NEXT:  pc_nxt = pc_r + 4'd1;
      COND_IN: begin
        go     = in_beat;
        pc_nxt = in_beat ? pc_r + 4'd1 : pc_r;
      end
      COND_MORE:  pc_nxt = more ? uw.target : pc_r + 4'd1;
      COND_EMPTY: pc_nxt = (good_r == '0) ? uw.target : pc_r + 4'd1;
      COND_CLAMP: pc_nxt = clamp ? uw.target : pc_r + 4'd1;
      COND_DIV: begin
        go     = !div_busy_r;
        pc_nxt = go ? pc_r + 4'd1 : pc_r;
      end
      COND_OUT: begin
        go     = out_free;
        pc_nxt = out_free ? uw.target : pc_r;
      end
      default:    pc_nxt = STEP_ACCEPT;
    endcase
  end

  // datapath next state
  always_comb begin
    ratio_nxt   = ratio_r;
    fs_nxt      = fs_r;
    pmin_nxt    = pmin_r;
    vmax_nxt    = vmax_r;
    raw_nxt     = raw_r;
    read_ok_nxt = read_ok_r;
    cal_ok_nxt  = cal_ok_r;
    cal_mv_nxt  = cal_mv_r;
    usb_nxt     = usb_r;
    attempt_nxt = attempt_r;
    good_nxt    = good_r;
    sum_nxt     = sum_r;
    prod_nxt    = prod_r;
    bat_nxt     = bat_r;
    pct_nxt     = pct_r;
    o_bat_nxt   = o_bat_r;
    o_pct_nxt   = o_pct_r;
    o_ext_nxt   = o_ext_r;
    o_none_nxt  = o_none_r;
    ov_nxt      = ov_r && !out_ch.ready;

    // divider iteration
    div_busy_nxt = div_busy_r;
    div_cnt_nxt  = div_cnt_r;
    div_quo_nxt  = div_quo_r;
    div_rem_nxt  = div_rem_r;
    div_den_nxt  = div_den_r;
    if (div_busy_r) begin
      div_rem_nxt  = div_fits ? DEN_W'(div_trial - {1'b0, div_den_r}) : div_trial[DEN_W-1:0];
      div_quo_nxt  = {div_quo_r[DIV_W-2:0], div_fits};
      div_cnt_nxt  = div_cnt_r - 5'd1;
      div_busy_nxt = div_cnt_r != 5'd1;
    end

    // register writes
    if (cfg_wr) begin
      case (ble_reg_t'(paddr[3:2]))
        REG_DIVIDER_RATIO: ratio_nxt = pwdata[RAT_W-1:0];
        REG_FULL_SCALE:    fs_nxt    = pwdata[MV_W-1:0];
        REG_PRESENT_MIN:   pmin_nxt  = pwdata[THR_W-1:0];
        REG_VALID_MAX:     vmax_nxt  = pwdata[THR_W-1:0];
        default:           ratio_nxt = ratio_r;
      endcase
    end

    // step operation
    if (go) begin
      unique case (uw.op)
        OP_NONE: ;
        OP_LATCH: begin
          raw_nxt     = in_ch.raw_code;
          read_ok_nxt = in_ch.read_ok;
          cal_ok_nxt  = in_ch.cal_ok;
          cal_mv_nxt  = in_ch.cal_mv;
          usb_nxt     = in_ch.usb_present;
        end
        OP_SCALE: prod_nxt = {4'd0, 24'({12'd0, raw_r} * {12'd0, fs_r})};
        OP_SAMPLE: begin
          if (read_ok_r) begin
            sum_nxt  = sum_r + {4'd0, sample_mv};
            good_nxt = good_r + 5'd1;
          end
          if (more) begin
            attempt_nxt = attempt_r + 4'd1;
          end
        end
        OP_WINDOW: begin
          prod_nxt = PROD_W'({12'd0, sum_r} * {16'd0, ratio_r})
                   + PROD_W'({good_r, 7'd0});
        end
        OP_DIV_AVG: begin
          div_busy_nxt = 1'b1;
          div_cnt_nxt  = DCNT_W'(DIV_W);
          div_quo_nxt  = prod_r[PROD_W-1:8];
          div_rem_nxt  = '0;
          div_den_nxt  = {4'd0, good_r};
        end
        OP_SAT: bat_nxt = (div_quo_r > 20'd65535) ? 16'hFFFF : div_quo_r[BAT_W-1:0];
        OP_DIV_SOC: begin
          if (clamp) begin
            pct_nxt = clamp_hi ? PCT_FULL : PCT_EMPTY;
          end else begin
            div_busy_nxt = 1'b1;
            div_cnt_nxt  = DCNT_W'(DIV_W);
            div_quo_nxt  = {7'd0, soc_num};
            div_rem_nxt  = '0;
            div_den_nxt  = {seg_span, 1'b0};
          end
        end
        OP_PCT: pct_nxt = curve_pct(seg + 4'd1) + div_quo_r[PCT_W-1:0];
        OP_EMIT: begin
          ov_nxt      = 1'b1;
          o_bat_nxt   = bat_r;
          o_pct_nxt   = pct_r;
          o_ext_nxt   = usb_r || (bat_r < {1'b0, pmin_r}) || (bat_r > {1'b0, vmax_r});
          o_none_nxt  = 1'b0;
          attempt_nxt = '0;
          good_nxt    = '0;
          sum_nxt     = '0;
        end
        OP_EMIT_EMPTY: begin
          ov_nxt      = 1'b1;
          o_bat_nxt   = '0;
          o_pct_nxt   = '0;
          o_ext_nxt   = 1'b0;
          o_none_nxt  = 1'b1;
          attempt_nxt = '0;
          good_nxt    = '0;
          sum_nxt     = '0;
        end
        default: ;
      endcase
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= STEP_ACCEPT;
      ratio_r    <= RESET_RATIO;
      fs_r       <= RESET_FULL_SCALE;
      pmin_r     <= RESET_PRESENT;
      vmax_r     <= RESET_VALID_MAX;
      attempt_r  <= '0;
      good_r     <= '0;
      sum_r      <= '0;
      div_busy_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      pc_r       <= pc_nxt;
      ratio_r    <= ratio_nxt;
      fs_r       <= fs_nxt;
      pmin_r     <= pmin_nxt;
      vmax_r     <= vmax_nxt;
      attempt_r  <= attempt_nxt;
      good_r     <= good_nxt;
      sum_r      <= sum_nxt;
      div_busy_r <= div_busy_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    raw_r     <= raw_nxt;
    read_ok_r <= read_ok_nxt;
    cal_ok_r  <= cal_ok_nxt;
    cal_mv_r  <= cal_mv_nxt;
    usb_r     <= usb_nxt;
    prod_r    <= prod_nxt;
    bat_r     <= bat_nxt;
    pct_r     <= pct_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_quo_r <= div_quo_nxt;
    div_rem_r <= div_rem_nxt;
    div_den_r <= div_den_nxt;
    o_bat_r   <= o_bat_nxt;
    o_pct_r   <= o_pct_nxt;
    o_ext_r   <= o_ext_nxt;
    o_none_r  <= o_none_nxt;
  end

endmodule

`default_nettype wire
